@@ hdl/bba_pkg.sv @@
// Shared types, constants and saturating arithmetic for the bounding box accumulator.
// No dependencies; used by every module under hdl/.
package bba_pkg;

  localparam int COORD_W = 32;
  localparam int AXES    = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    MODE_CONTAIN   = 2'd0,
    MODE_EXPAND    = 2'd1,
    MODE_TRANSLATE = 2'd2,
    MODE_CLEAR     = 2'd3
  } mode_t;

  // +1.0 and -1.0 in 16.16
  localparam coord_t BOX_LO_RST = 32'sh0001_0000;
  localparam coord_t BOX_HI_RST = 32'shFFFF_0000;
  localparam coord_t COORD_MAX  = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN  = 32'sh8000_0000;

  // per-lane flags on the box as it stands before the request
  typedef struct packed {
    logic ordered;   // lo <= hi on this axis
    logic between;   // lo < p < hi on this axis
  } lane_stat_t;

  typedef struct packed {
    logic was_valid;
    logic pt_inside;
  } merge_t;

  typedef struct packed {
    coord_t [AXES-1:0] hi;
    coord_t [AXES-1:0] lo;
    logic              pt_inside;
  } result_t;

  function automatic coord_t sat_add(input coord_t a, input coord_t b);
    logic [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      sat_add = s[COORD_W] ? COORD_MIN : COORD_MAX;
    end else begin
      sat_add = s[COORD_W-1:0];
    end
  endfunction

  function automatic coord_t sat_sub(input coord_t a, input coord_t b);
    logic [COORD_W:0] s;
    s = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      sat_sub = s[COORD_W] ? COORD_MIN : COORD_MAX;
    end else begin
      sat_sub = s[COORD_W-1:0];
    end
  endfunction

endpackage

@@ hdl/bba_lane.sv @@
// One axis of the box: holds min/max for that axis and applies each request.
// Depends on bba_pkg.
module bba_lane (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  bba_pkg::mode_t      mode,
  input  bba_pkg::coord_t     p,
  input  bba_pkg::coord_t     r,
  input  logic                was_valid,
  output bba_pkg::coord_t     lo,
  output bba_pkg::coord_t     hi,
  output bba_pkg::coord_t     lo_next,
  output bba_pkg::coord_t     hi_next,
  output bba_pkg::lane_stat_t stat
);

  bba_pkg::coord_t cand_lo;
  bba_pkg::coord_t cand_hi;

  always_comb begin
    if (mode == bba_pkg::MODE_EXPAND) begin
      cand_lo = bba_pkg::sat_sub(p, r);
      cand_hi = bba_pkg::sat_add(p, r);
    end else begin
      cand_lo = p;
      cand_hi = p;
    end
  end

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    case (mode)
      bba_pkg::MODE_CONTAIN, bba_pkg::MODE_EXPAND: begin
        if (was_valid) begin
          lo_next = (cand_lo < lo) ? cand_lo : lo;
          hi_next = (cand_hi > hi) ? cand_hi : hi;
        end else begin
          lo_next = cand_lo;
          hi_next = cand_hi;
        end
      end
      bba_pkg::MODE_TRANSLATE: begin
        if (was_valid) begin
          lo_next = bba_pkg::sat_add(lo, p);
          hi_next = bba_pkg::sat_add(hi, p);
        end
      end
      default: begin
        lo_next = bba_pkg::BOX_LO_RST;
        hi_next = bba_pkg::BOX_HI_RST;
      end
    endcase
  end

  assign stat.ordered = (lo <= hi);
  assign stat.between = (p > lo) && (p < hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      lo <= bba_pkg::BOX_LO_RST;
      hi <= bba_pkg::BOX_HI_RST;
    end else if (accept) begin
      lo <= lo_next;
      hi <= hi_next;
    end
  end

endmodule

@@ hdl/bba_merge.sv @@
// Combines the per-axis flags of the lanes into box validity and point containment.
// Depends on bba_pkg.
module bba_merge (
  input  bba_pkg::lane_stat_t [bba_pkg::AXES-1:0] stat,
  output bba_pkg::merge_t                         merged
);

  always_comb begin
    merged.was_valid = 1'b1;
    merged.pt_inside = 1'b1;
    for (int a = 0; a < bba_pkg::AXES; a++) begin
      merged.was_valid = merged.was_valid & stat[a].ordered;
      merged.pt_inside = merged.pt_inside & stat[a].between;
    end
    merged.pt_inside = merged.pt_inside & merged.was_valid;
  end

endmodule

@@ hdl/bba_out.sv @@
// Two-entry output buffer (output register plus skid register) for result requests.
// Depends on bba_pkg.
module bba_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bba_pkg::result_t   din,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output bba_pkg::result_t   dout,
  output logic               box_valid
);

  logic             o_valid;
  logic             k_valid;
  bba_pkg::result_t o_data;
  bba_pkg::result_t k_data;
  logic             take;

  assign take      = o_valid && out_ready;
  assign in_ready  = !k_valid;
  assign out_valid = o_valid;
  assign dout      = o_data;

  always_comb begin
    box_valid = 1'b1;
    for (int a = 0; a < bba_pkg::AXES; a++) begin
      box_valid = box_valid & ($signed(o_data.lo[a]) <= $signed(o_data.hi[a]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      k_valid <= 1'b0;
    end else if (take) begin
      if (k_valid) begin
        k_valid <= 1'b0;
      end else if (!push) begin
        o_valid <= 1'b0;
      end
    end else if (push) begin
      if (!o_valid) begin
        o_valid <= 1'b1;
      end else begin
        k_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (k_valid) begin
        o_data <= k_data;
      end else if (push) begin
        o_data <= din;
      end
    end else if (push) begin
      if (!o_valid) begin
        o_data <= din;
      end else begin
        k_data <= din;
      end
    end
  end

endmodule

@@ hdl/bounding_box_accumulator.sv @@
// Results are registered on accept and reach m_tdata in order, behind any result still held.
// Throughput: one request per cycle while s_tready is high; all three axis lanes update in the accept cycle.
// A two-entry output buffer keeps s_tready high while one result waits on m_tready.
// Reset (rst, synchronous, active high) empties the buffer and sets the box to the
// invalid state min = +1.0, max = -1.0 on every axis. Depends on bba_pkg and submodules.
module bounding_box_accumulator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // px, py, pz, radius
  input  logic [1:0]   s_tuser,   // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,   // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
  output logic [1:0]   m_tuser    // box_valid, point_inside
);

  logic                                    accept;
  bba_pkg::mode_t                          mode;
  bba_pkg::coord_t [bba_pkg::AXES-1:0]     p;
  bba_pkg::coord_t                         r;
  bba_pkg::coord_t [bba_pkg::AXES-1:0]     lo;
  bba_pkg::coord_t [bba_pkg::AXES-1:0]     hi;
  bba_pkg::coord_t [bba_pkg::AXES-1:0]     lo_next;
  bba_pkg::coord_t [bba_pkg::AXES-1:0]     hi_next;
  bba_pkg::lane_stat_t [bba_pkg::AXES-1:0] stat;
  bba_pkg::merge_t                         merged;
  bba_pkg::result_t                        res;
  bba_pkg::result_t                        res_out;
  logic                                    box_valid;

  assign accept = s_tvalid && s_tready;
  assign mode   = bba_pkg::mode_t'(s_tuser);
  assign p[0]   = s_tdata[31:0];
  assign p[1]   = s_tdata[63:32];
  assign p[2]   = s_tdata[95:64];
  assign r      = s_tdata[127:96];

  for (genvar a = 0; a < bba_pkg::AXES; a++) begin : g_lane
    bba_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .accept    (accept),
      .mode      (mode),
      .p         (p[a]),
      .r         (r),
      .was_valid (merged.was_valid),
      .lo        (lo[a]),
      .hi        (hi[a]),
      .lo_next   (lo_next[a]),
      .hi_next   (hi_next[a]),
      .stat      (stat[a])
    );
  end

  bba_merge u_merge (
    .stat   (stat),
    .merged (merged)
  );

  assign res.lo        = lo_next;
  assign res.hi        = hi_next;
  assign res.pt_inside = merged.pt_inside;

  bba_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .din       (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .dout      (res_out),
    .box_valid (box_valid)
  );

  assign m_tdata = {res_out.hi, res_out.lo};
  assign m_tuser = {res_out.pt_inside, box_valid};

  a_ready_needs_full : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output register");

  a_clear_invalid : assert property (@(posedge clk) disable iff (rst)
    accept && mode == bba_pkg::MODE_CLEAR |=> !merged.was_valid)
    else $error("box valid after clear");

  a_contain_valid : assert property (@(posedge clk) disable iff (rst)
    accept && mode == bba_pkg::MODE_CONTAIN |=> merged.was_valid)
    else $error("box invalid after contain");

  a_translate_hold : assert property (@(posedge clk) disable iff (rst)
    accept && mode == bba_pkg::MODE_TRANSLATE && !merged.was_valid
    |=> $stable(lo) && $stable(hi))
    else $error("translate changed an invalid box");

  a_inside_valid : assert property (@(posedge clk) disable iff (rst)
    accept && merged.pt_inside |=> m_tvalid)
    else $error("result missing after accepted request");

endmodule
